// ===== rtl/packed_signed_varint_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packed signed varint decoder
// Shared property forms, each gated by the asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef PACKED_SIGNED_VARINT_DECODER_UNIT_ASSERT_SVH
`define PACKED_SIGNED_VARINT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication
`define PSVD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psvd assertion failed");

// Next-cycle implication
`define PSVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("psvd assertion failed");

`endif

// ===== rtl/psvd_pkg.sv =====
// ----------------------------------------------------------------------------
// psvd_pkg
// Types and constants of the packed signed varint decoder.
// ----------------------------------------------------------------------------
package psvd_pkg;

	// Byte layout
	localparam logic [7:0] FIRST_DATA_MASK = 8'h3F;
	localparam logic [7:0] NEXT_DATA_MASK  = 8'h7F;
	localparam int unsigned SIGN_BIT_POS   = 6;
	localparam int unsigned CONT_BIT_POS   = 7;

	// Width modes (code three acts as 64 bits)
	localparam logic [1:0] MODE_W16 = 2'd0;
	localparam logic [1:0] MODE_W32 = 2'd1;
	localparam logic [1:0] MODE_W64 = 2'd2;
	localparam logic [1:0] MODE_RESET = MODE_W32;

	// Longest legal run per width
	localparam logic [3:0] MAX_LEN_W16 = 4'd3;
	localparam logic [3:0] MAX_LEN_W32 = 4'd5;
	localparam logic [3:0] MAX_LEN_W64 = 4'd10;

	localparam logic [3:0] COUNT_MAX = 4'd15;
	localparam logic [6:0] POS_FIRST = 7'd6;
	localparam logic [6:0] POS_MAX   = 7'd127;
	localparam logic [7:0] POS_STEP  = 8'd7;

	// Finished run handed from the accumulator to the output stage
	typedef struct packed {
		logic [63:0] acc;
		logic        negative;
		logic [3:0]  byte_count;
		logic        overflow;
	} psvd_rec_t;

endpackage

// ===== rtl/psvd_if.sv =====
// ----------------------------------------------------------------------------
// psvd channel interfaces
// Valid/ready channels for the byte stream and the decoded results.
// ----------------------------------------------------------------------------
interface psvd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface psvd_result_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic [3:0]         byte_count;
	logic               overflow;

	modport source (output valid, output value, output byte_count, output overflow,
		input ready);
	modport sink (input valid, input value, input byte_count, input overflow,
		output ready);
endinterface

// ===== rtl/psvd_accum.sv =====
// ----------------------------------------------------------------------------
// psvd_accum
// Collects data bits of each run, one byte per cycle unless the hand-off stage stalls; hands finished runs on.
// ----------------------------------------------------------------------------
module psvd_accum import psvd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	psvd_byte_if.sink  byte_in,
	input  logic       s1_ready,
	output logic       valid_s1,
	output psvd_rec_t  rec_s1
);

	`include "packed_signed_varint_decoder_unit_assert.svh"

	logic [63:0] accumulator_q;
	logic [6:0]  bit_position_q;
	logic        negative_flag_q;
	logic        in_value_q;
	logic [3:0]  bytes_seen_q;
	logic        overflow_seen_q;

	logic        fire;
	logic        cont;
	logic [7:0]  first_data;
	logic [7:0]  next_data;
	logic [70:0] placed;
	logic [7:0]  pos_sum;

	logic [63:0] acc_n;
	logic [6:0]  pos_n;
	logic        neg_n;
	logic [3:0]  bytes_n;
	logic        ovf_n;

	// Accept while the hand-off stage is free or draining
	assign byte_in.ready = !valid_s1 || s1_ready;
	assign fire = byte_in.valid && byte_in.ready;
	assign cont = byte_in.in_byte[CONT_BIT_POS];

	assign first_data = byte_in.in_byte & FIRST_DATA_MASK;
	assign next_data  = byte_in.in_byte & NEXT_DATA_MASK;
	assign placed     = 71'(next_data[6:0]) << bit_position_q[5:0];
	assign pos_sum    = {1'b0, bit_position_q} + POS_STEP;

	// Fold the incoming byte into the run
	always_comb begin
		if (!in_value_q) begin
			acc_n   = {58'd0, first_data[5:0]};
			pos_n   = POS_FIRST;
			neg_n   = byte_in.in_byte[SIGN_BIT_POS];
			bytes_n = 4'd1;
			ovf_n   = 1'b0;
		end else begin
			neg_n   = negative_flag_q;
			pos_n   = pos_sum[7] ? POS_MAX : pos_sum[6:0];
			bytes_n = (bytes_seen_q == COUNT_MAX) ? COUNT_MAX : bytes_seen_q + 4'd1;
			if (!bit_position_q[6]) begin
				acc_n = accumulator_q | placed[63:0];
				ovf_n = overflow_seen_q | (|placed[70:64]);
			end else begin
				// Bits landing past bit 63 are dropped
				acc_n = accumulator_q;
				ovf_n = overflow_seen_q | (|next_data[6:0]);
			end
		end
	end

	// Run state: advance on a continuation byte, clear on a final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accumulator_q   <= '0;
			bit_position_q  <= '0;
			negative_flag_q <= 1'b0;
			in_value_q      <= 1'b0;
			bytes_seen_q    <= '0;
			overflow_seen_q <= 1'b0;
		end else if (fire) begin
			if (cont) begin
				accumulator_q   <= acc_n;
				bit_position_q  <= pos_n;
				negative_flag_q <= neg_n;
				in_value_q      <= 1'b1;
				bytes_seen_q    <= bytes_n;
				overflow_seen_q <= ovf_n;
			end else begin
				accumulator_q   <= '0;
				bit_position_q  <= '0;
				negative_flag_q <= 1'b0;
				in_value_q      <= 1'b0;
				bytes_seen_q    <= '0;
				overflow_seen_q <= 1'b0;
			end
		end
	end

	// Hand-off stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire && !cont) begin
			valid_s1 <= 1'b1;
		end else if (s1_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hand-off stage payload
	always_ff @(posedge clk) begin
		if (fire && !cont) begin
			rec_s1 <= '{acc: acc_n, negative: neg_n, byte_count: bytes_n, overflow: ovf_n};
		end
	end

	`PSVD_ASSERT_NEXT(a_final_clears, clk, arst_n, fire && !cont,
		!in_value_q && bytes_seen_q == 4'd0)
	`PSVD_ASSERT_IMP(a_run_active, clk, arst_n, in_value_q,
		bytes_seen_q != 4'd0 && bit_position_q >= POS_FIRST)
	`PSVD_ASSERT_IMP(a_open_ready, clk, arst_n, !valid_s1, byte_in.ready)

endmodule

// ===== rtl/psvd_finish.sv =====
// ----------------------------------------------------------------------------
// psvd_finish
// Applies sign and width to a finished run and holds the result item.
// ----------------------------------------------------------------------------
module psvd_finish import psvd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    value_width_mode,
	input  logic          valid_s1,
	input  psvd_rec_t     rec_s1,
	output logic          s1_ready,
	psvd_result_if.source result
);

	`include "packed_signed_varint_decoder_unit_assert.svh"

	logic               out_valid_q;
	logic signed [63:0] value_q;
	logic [3:0]         byte_count_q;
	logic               overflow_q;

	logic        take;
	logic [63:0] mag;
	logic [63:0] value_n;
	logic        high_bits;
	logic [3:0]  max_len;

	assign s1_ready = !out_valid_q || result.ready;
	assign take = valid_s1 && s1_ready;

	assign mag = rec_s1.negative ? ~rec_s1.acc : rec_s1.acc;

	// Cut to the configured width and sign-extend
	always_comb begin
		unique case (value_width_mode)
			MODE_W16: begin
				value_n   = {{48{mag[15]}}, mag[15:0]};
				high_bits = |rec_s1.acc[63:16];
				max_len   = MAX_LEN_W16;
			end
			MODE_W32: begin
				value_n   = {{32{mag[31]}}, mag[31:0]};
				high_bits = |rec_s1.acc[63:32];
				max_len   = MAX_LEN_W32;
			end
			default: begin
				value_n   = mag;
				high_bits = 1'b0;
				max_len   = MAX_LEN_W64;
			end
		endcase
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			value_q      <= value_n;
			byte_count_q <= rec_s1.byte_count;
			overflow_q   <= rec_s1.overflow | high_bits | (rec_s1.byte_count > max_len);
		end
	end

	assign result.valid      = out_valid_q;
	assign result.value      = value_q;
	assign result.byte_count = byte_count_q;
	assign result.overflow   = overflow_q;

	`PSVD_ASSERT_IMP(a_clean_len, clk, arst_n, out_valid_q && !overflow_q,
		byte_count_q <= MAX_LEN_W64 && byte_count_q != 4'd0)
	`PSVD_ASSERT_NEXT(a_take_loads, clk, arst_n, take, out_valid_q)
	`PSVD_ASSERT_NEXT(a_hold_result, clk, arst_n, out_valid_q && !result.ready,
		out_valid_q && $stable(value_q))

endmodule

// ===== rtl/packed_signed_varint_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// packed_signed_varint_decoder_unit
// Decodes sign-prefixed varints from a byte stream into 64-bit signed values.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle on byte_in while the hand-off register can
// take a finished run; each byte is shifted and ORed into the run accumulator.
// The result item of a run passes through the hand-off register, then the
// output register, before it appears on result.
// While a result item waits, input keeps flowing until the next finished run
// fills the hand-off register; byte_in then stalls until result accepts.
// cfg_we/cfg_wdata set the width mode (0 = 16, 1 = 32, 2 or 3 = 64 bits,
// reset 32); write it only while no result is pending.
module packed_signed_varint_decoder_unit import psvd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	psvd_byte_if.sink     byte_in,
	psvd_result_if.source result,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata
);

	logic [1:0] value_width_mode_q;
	logic       valid_s1;
	logic       s1_ready;
	psvd_rec_t  rec_s1;

	// Width mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_width_mode_q <= MODE_RESET;
		end else if (cfg_we) begin
			value_width_mode_q <= cfg_wdata;
		end
	end

	psvd_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.s1_ready (s1_ready),
		.valid_s1 (valid_s1),
		.rec_s1   (rec_s1)
	);

	psvd_finish u_finish (
		.clk              (clk),
		.arst_n           (arst_n),
		.value_width_mode (value_width_mode_q),
		.valid_s1         (valid_s1),
		.rec_s1           (rec_s1),
		.s1_ready         (s1_ready),
		.result           (result)
	);

endmodule
